@@ rtl/first_order_iir_with_soft_start_limit_defines.svh @@
// Assertion macros shared by the filter's RTL modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FIRST_ORDER_IIR_WITH_SOFT_START_LIMIT_DEFINES_SVH
`define FIRST_ORDER_IIR_WITH_SOFT_START_LIMIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define FOI_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FOI_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/foi_pkg.sv @@
// Types, widths and constants of the first-order IIR filter.
// Depends on nothing; used by the interfaces, the multiplier, the divider and the top module.
package foi_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int STEP_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int QUO_W     = DATA_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DATA_W-1:0] COEF_ONE = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0        = 3'd0,
        CFG_B1        = 3'd1,
        CFG_A0        = 3'd2,
        CFG_A1        = 3'd3,
        CFG_SAT_EN    = 3'd4,
        CFG_SAT_MIN   = 3'd5,
        CFG_SAT_MAX   = 3'd6,
        CFG_SS_STEPS  = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  num_mag;
        logic [DATA_W-1:0] den_mag;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage

@@ rtl/foi_if.sv @@
// Handshake channels of the filter: sample input, result output, register writes.
// Depends on foi_pkg for the payload widths.
interface foi_in_if;
    import foi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [DATA_W-1:0] sample;
    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

interface foi_out_if;
    import foi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     saturated;
    modport source (output valid, output value, output saturated, input ready);
    modport sink   (input valid, input value, input saturated, output ready);
endinterface

interface foi_cfg_if;
    import foi_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

@@ rtl/foi_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on foi_pkg for the operand and product widths.
module foi_mul (
    input  logic                              i_clk,
    input  logic signed [foi_pkg::DATA_W-1:0] i_a,
    input  logic signed [foi_pkg::DATA_W-1:0] i_b,
    output logic signed [foi_pkg::PROD_W-1:0] o_prod
);
    import foi_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/foi_div.sv @@
// Restoring serial divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on foi_pkg and the assertion macro header.
`include "first_order_iir_with_soft_start_limit_defines.svh"

module foi_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  foi_pkg::t_div_req i_req,
    output foi_pkg::t_div_rsp o_rsp
);
    import foi_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic [QUO_W-1:0]  r_dvd;
    logic [QUO_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   den_ext;
    logic              fits;

    // The caller guarantees that the dividend bits above the quotient field
    // are already below the divisor, so they seed the partial remainder.
    assign trial   = {r_rem, r_dvd[QUO_W-1]};
    assign den_ext = {1'b0, r_den};
    assign fits    = trial >= den_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.num_mag[QUO_W+DATA_W-1:QUO_W];
                r_dvd  <= i_req.num_mag[QUO_W-1:0];
                r_den  <= i_req.den_mag;
                r_quo  <= '0;
                r_cnt  <= CNT_W'(QUO_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[QUO_W-2:0], 1'b0};
                if (fits) begin
                    r_rem <= DATA_W'(trial - den_ext);
                    r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[DATA_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    `FOI_ASSERT_IMP(a_div_no_restart, i_clk, i_rst_n, i_req.start, !r_busy, "divider restarted while busy")
    `FOI_ASSERT_IMP(a_div_busy_cnt, i_clk, i_rst_n, r_busy, r_cnt != '0, "divider busy with no bits left")
    `FOI_ASSERT_NXT(a_div_done_pulse, i_clk, i_rst_n, r_done, !r_done && !r_busy, "divider done held")

endmodule

@@ rtl/first_order_iir_with_soft_start_limit.sv @@
// A filter beat runs the products, the magnitude and divisor checks and the serial divider;
// a zero divisor or an overflowing quotient skips the divider and gives zero or a saturated value.
// While the soft-start ramp is active each beat adds two limit divides.
// A clear beat goes from S_IDLE straight to S_FIN. One beat is in flight at a time,
// so the next beat waits until S_FIN registers the result, which stalls while the output drains.
// Synchronous active-low reset restores register defaults and zeroes history, step and flag.
`include "first_order_iir_with_soft_start_limit_defines.svh"

module first_order_iir_with_soft_start_limit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    foi_in_if.sink    i_in,
    foi_out_if.source o_out,
    foi_cfg_if.sink   i_cfg
);
    import foi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_MAG, S_CHK, S_DIV,
        S_SAT, S_SSM, S_SSP, S_SSS, S_SSD, S_FIN
    } t_state;

    t_state r_state;

    logic signed [DATA_W-1:0] r_b0, r_b1, r_a0, r_a1, r_sat_min, r_sat_max;
    logic                     r_sat_en;
    logic [STEP_W-1:0]        r_ss_steps;

    logic signed [DATA_W-1:0] r_prev_in, r_prev_out, r_x, r_y;
    logic [STEP_W-1:0]        r_step;
    logic                     r_sat_flag;
    logic                     r_clear;
    logic                     r_lim_hi;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]         r_mag;
    logic                     r_neg;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_sat;

    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic [DATA_W-1:0]        a0_mag;
    logic                     a0_zero;
    logic                     quo_ovf;
    logic                     ss_active;
    logic signed [DATA_W-1:0] div_val;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    function automatic logic signed [DATA_W-1:0] clamp_quo(
        input logic             neg,
        input logic [QUO_W-1:0] mag
    );
        logic [QUO_W-1:0] neg_mag;
        neg_mag = ~mag + 1'b1;
        if (neg) begin
            if (mag > {1'b0, DATA_MIN}) begin
                return DATA_MIN;
            end
            return neg_mag[DATA_W-1:0];
        end
        if (mag[QUO_W-1] || mag[DATA_W-1]) begin
            return DATA_MAX;
        end
        return mag[DATA_W-1:0];
    endfunction

    foi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    foi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign prod_ext  = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    assign a0_mag    = r_a0[DATA_W-1] ? DATA_W'(-r_a0) : r_a0;
    assign a0_zero   = (r_a0 == '0);
    // A quotient of 2^33 or more can only saturate, so the divider is skipped.
    assign quo_ovf   = r_mag[ACC_W-1:QUO_W] >= {1'b0, a0_mag};
    assign ss_active = (r_ss_steps != '0) && (r_step < r_ss_steps);
    assign div_val   = clamp_quo(r_neg, div_rsp.quo);

    always_comb begin
        unique case (r_state)
            S_M1: begin
                mul_a = r_b1;
                mul_b = r_prev_in;
            end
            S_M2: begin
                mul_a = r_a1;
                mul_b = r_prev_out;
            end
            S_SSM: begin
                mul_a = r_lim_hi ? r_sat_max : r_sat_min;
                mul_b = {{(DATA_W-STEP_W){1'b0}}, r_step};
            end
            default: begin
                mul_a = r_b0;
                mul_b = r_x;
            end
        endcase
    end

    always_comb begin
        div_req.start   = ((r_state == S_CHK) && !a0_zero && !quo_ovf) || (r_state == S_SSS);
        div_req.num_mag = r_mag;
        div_req.den_mag = (r_state == S_SSS) ? {{(DATA_W-STEP_W){1'b0}}, r_ss_steps} : a0_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_b0        <= COEF_ONE;
            r_b1        <= '0;
            r_a0        <= COEF_ONE;
            r_a1        <= '0;
            r_sat_en    <= 1'b0;
            r_sat_min   <= '0;
            r_sat_max   <= '0;
            r_ss_steps  <= '0;
            r_prev_in   <= '0;
            r_prev_out  <= '0;
            r_step      <= '0;
            r_sat_flag  <= 1'b0;
            r_clear     <= 1'b0;
            r_lim_hi    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (t_cfg_idx'(i_cfg.idx))
                    CFG_B0:       r_b0       <= i_cfg.data;
                    CFG_B1:       r_b1       <= i_cfg.data;
                    CFG_A0:       r_a0       <= i_cfg.data;
                    CFG_A1:       r_a1       <= i_cfg.data;
                    CFG_SAT_EN:   r_sat_en   <= i_cfg.data[0];
                    CFG_SAT_MIN:  r_sat_min  <= i_cfg.data;
                    CFG_SAT_MAX:  r_sat_max  <= i_cfg.data;
                    CFG_SS_STEPS: r_ss_steps <= i_cfg.data[STEP_W-1:0];
                endcase
            end

            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_x     <= i_in.sample;
                        r_clear <= (t_op'(i_in.op) == OP_CLEAR);
                        r_state <= (t_op'(i_in.op) == OP_CLEAR) ? S_FIN : S_M0;
                    end
                end
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_acc   <= prod_ext;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_acc   <= r_acc + prod_ext;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_acc   <= r_acc - prod_ext;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_neg   <= r_acc[ACC_W-1];
                    r_mag   <= r_acc[ACC_W-1] ? ACC_W'(-r_acc) : r_acc;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (a0_zero || quo_ovf) begin
                        if (r_mag == '0) begin
                            r_y <= '0;
                        end else begin
                            // The quotient's sign also takes the divisor's sign.
                            r_y <= (r_neg ^ r_a0[DATA_W-1]) ? DATA_MIN : DATA_MAX;
                        end
                        r_state <= S_SAT;
                    end else begin
                        r_neg   <= r_neg ^ r_a0[DATA_W-1];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_y     <= div_val;
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (r_sat_en) begin
                        if (r_y > r_sat_max) begin
                            r_y        <= r_sat_max;
                            r_sat_flag <= 1'b1;
                        end else if (r_y < r_sat_min) begin
                            r_y        <= r_sat_min;
                            r_sat_flag <= 1'b1;
                        end else begin
                            r_sat_flag <= 1'b0;
                        end
                    end
                    r_lim_hi <= 1'b1;
                    r_state  <= ss_active ? S_SSM : S_FIN;
                end
                S_SSM: r_state <= S_SSP;
                S_SSP: begin
                    r_neg   <= prod[PROD_W-1];
                    r_mag   <= prod[PROD_W-1] ? ACC_W'(-prod_ext) : prod_ext;
                    r_state <= S_SSS;
                end
                S_SSS: r_state <= S_SSD;
                S_SSD: begin
                    if (div_rsp.done) begin
                        // The upper scaled limit is applied first, the lower one last.
                        if (r_lim_hi) begin
                            if (r_y > div_val) begin
                                r_y <= div_val;
                            end
                            r_lim_hi <= 1'b0;
                            r_state  <= S_SSM;
                        end else begin
                            if (r_y < div_val) begin
                                r_y <= div_val;
                            end
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_sat   <= r_sat_flag;
                        if (r_clear) begin
                            r_out_value <= '0;
                            r_prev_in   <= '0;
                            r_prev_out  <= '0;
                            r_step      <= '0;
                        end else begin
                            r_out_value <= r_y;
                            r_prev_in   <= r_x;
                            r_prev_out  <= r_y;
                            if (r_step != '1) begin
                                r_step <= r_step + 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.value     = r_out_value;
    assign o_out.saturated = r_out_sat;

    `FOI_ASSERT_IMP(a_div_alive, i_clk, i_rst_n, (r_state == S_DIV) || (r_state == S_SSD), div_rsp.busy || div_rsp.done, "waiting on an idle divider")
    `FOI_ASSERT_NXT(a_flag_kept, i_clk, i_rst_n, (r_state == S_SAT) && !r_sat_en, $stable(r_sat_flag), "saturation flag changed while clamping is off")
    `FOI_ASSERT_NXT(a_clear_zero, i_clk, i_rst_n, (r_state == S_FIN) && r_clear && !r_out_valid, r_out_valid && (r_out_value == '0) && (r_step == '0), "clear beat left a nonzero result or step")

endmodule
